>>> hdl/ctf_pkg.sv
// package for the complementary tilt filter: state enum, command and status
// structs, cordic angle table. no dependencies.
package ctf_pkg;

  localparam int unsigned TabLen   = 24;
  localparam int unsigned GainFrac = 24;

  localparam logic [1:0] REG_GYRO_GAIN = 2'd0;
  localparam logic [1:0] REG_BLEND     = 2'd1;
  localparam logic [1:0] REG_MAG_LOW   = 2'd2;
  localparam logic [1:0] REG_MAG_HIGH  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GYRO,
    ST_CHECK,
    ST_CORDIC,
    ST_BLEND,
    ST_OUT
  } ctf_state_t;

  typedef struct packed {
    logic load;
    logic gyro;
    logic cordic_start;
    logic cordic_step;
    logic blend;
    logic finish;
  } ctf_cmd_t;

  typedef struct packed {
    logic in_window;
    logic cordic_last;
  } ctf_status_t;

  function automatic logic [29:0] atan_q24(input logic [4:0] i);
    case (i)
      5'd0:  atan_q24 = 30'd754974720;
      5'd1:  atan_q24 = 30'd445687601;
      5'd2:  atan_q24 = 30'd235489088;
      5'd3:  atan_q24 = 30'd119537938;
      5'd4:  atan_q24 = 30'd60000934;
      5'd5:  atan_q24 = 30'd30029717;
      5'd6:  atan_q24 = 30'd15018523;
      5'd7:  atan_q24 = 30'd7509720;
      5'd8:  atan_q24 = 30'd3754917;
      5'd9:  atan_q24 = 30'd1877466;
      5'd10: atan_q24 = 30'd938734;
      5'd11: atan_q24 = 30'd469367;
      5'd12: atan_q24 = 30'd234684;
      5'd13: atan_q24 = 30'd117342;
      5'd14: atan_q24 = 30'd58671;
      5'd15: atan_q24 = 30'd29335;
      5'd16: atan_q24 = 30'd14668;
      5'd17: atan_q24 = 30'd7334;
      5'd18: atan_q24 = 30'd3667;
      5'd19: atan_q24 = 30'd1833;
      5'd20: atan_q24 = 30'd917;
      5'd21: atan_q24 = 30'd458;
      5'd22: atan_q24 = 30'd229;
      5'd23: atan_q24 = 30'd115;
      default: atan_q24 = 30'd0;
    endcase
  endfunction

endpackage

>>> hdl/ctf_if.sv
// valid/ready channel interfaces for the tilt filter
// depends on nothing
interface ctf_sample_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;
  modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, output ready);
endinterface

interface ctf_angle_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [31:0] pitch_out;
  logic signed [31:0] roll_out;
  logic corrected;
  modport source (output valid, pitch_out, roll_out, corrected, input ready);
  modport sink (input valid, pitch_out, roll_out, corrected, output ready);
endinterface

>>> hdl/ctf_ctrl.sv
// sequencer for the tilt filter: steps one word through gyro, window check and,
// inside the window, cordic and blend. depends on ctf_pkg.
module ctf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  ctf_pkg::ctf_status_t  status,
  output ctf_pkg::ctf_cmd_t     cmd
);
  ctf_pkg::ctf_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ctf_pkg::ST_IDLE:   if (in_valid) state_next = ctf_pkg::ST_GYRO;
      ctf_pkg::ST_GYRO:   state_next = ctf_pkg::ST_CHECK;
      ctf_pkg::ST_CHECK: begin
        state_next = status.in_window ? ctf_pkg::ST_CORDIC : ctf_pkg::ST_OUT;
      end
      ctf_pkg::ST_CORDIC: if (status.cordic_last) state_next = ctf_pkg::ST_BLEND;
      ctf_pkg::ST_BLEND:  state_next = ctf_pkg::ST_OUT;
      ctf_pkg::ST_OUT:    if (out_ready) state_next = ctf_pkg::ST_IDLE;
      default:            state_next = ctf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      ctf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ctf_pkg::ST_GYRO:   cmd.gyro = 1'b1;
      ctf_pkg::ST_CHECK:  cmd.cordic_start = status.in_window;
      ctf_pkg::ST_CORDIC: cmd.cordic_step = 1'b1;
      ctf_pkg::ST_BLEND:  cmd.blend = 1'b1;
      ctf_pkg::ST_OUT: begin
        out_valid = 1'b1;
        cmd.finish = out_ready;
      end
      default: cmd = '0;
    endcase
  end
endmodule

>>> hdl/ctf_datapath.sv
// angle state, gyro integration, two shared-step cordic units and blend
// depends on ctf_pkg
module ctf_datapath #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctf_pkg::ctf_cmd_t     cmd,
  output ctf_pkg::ctf_status_t  status,
  input  logic signed [15:0]    accel_x,
  input  logic signed [15:0]    accel_y,
  input  logic signed [15:0]    accel_z,
  input  logic signed [15:0]    rate_x,
  input  logic signed [15:0]    rate_y,
  input  logic [23:0]           gyro_gain,
  input  logic [16:0]           blend_weight,
  input  logic [16:0]           magnitude_low,
  input  logic [16:0]           magnitude_high,
  output logic signed [31:0]    pitch_angle,
  output logic signed [31:0]    roll_angle,
  output logic                  corrected
);
  localparam int Sh = int'(ctf_pkg::GainFrac) - ANGLE_FRAC_BITS;
  localparam logic signed [41:0] GyroHalf = 42'sd1 <<< (Sh - 1);
  localparam logic signed [33:0] ZHalf = 34'sd1 <<< (Sh - 1);
  localparam logic [4:0] LastStep = 5'(CORDIC_STEPS - 1);
  localparam logic signed [33:0] Deg180 = 34'sd180 <<< ctf_pkg::GainFrac;
  localparam logic signed [33:0] Max32 = 34'sd2147483647;
  localparam logic signed [33:0] Min32 = -34'sd2147483648;

  logic signed [15:0] ax, ay, az, gx, gy;
  logic [4:0] step;
  // cordic vectors: 16-bit input times 2^16, grows by under two bits
  logic signed [34:0] px, py, rx, ry;
  // angle accumulators reach about 270 degrees in q.24
  logic signed [33:0] pz, rz;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (v > Max32) sat34 = 32'sh7fffffff;
    else if (v < Min32) sat34 = 32'sh80000000;
    else sat34 = v[31:0];
  endfunction

  function automatic logic signed [31:0] gyro_delta(input logic signed [15:0] r,
                                                    input logic [23:0] g);
    logic signed [41:0] p;
    p = 42'(r) * $signed({1'b0, g});
    gyro_delta = 32'((p + GyroHalf) >>> Sh);
  endfunction

  function automatic logic signed [31:0] round_z(input logic signed [33:0] z);
    round_z = 32'((z + ZHalf) >>> Sh);
  endfunction

  // gyro angle weighted by w, accel angle by 1 - w, products around 48 bits
  function automatic logic signed [31:0] mix(input logic signed [31:0] a,
                                             input logic signed [31:0] c,
                                             input logic [16:0] w);
    logic signed [50:0] s;
    s = 51'(a) * $signed({1'b0, w}) + 51'(c) * $signed(18'sd65536 - $signed({1'b0, w}))
        + 51'sd32768;
    mix = sat34(34'(s >>> 16));
  endfunction

  logic [17:0] mag;
  logic [16:0] wt;
  always_comb begin
    mag = 18'(ax[15] ? -17'(ax) : 17'(ax)) + 18'(ay[15] ? -17'(ay) : 17'(ay))
        + 18'(az[15] ? -17'(az) : 17'(az));
    status.in_window = (mag > 18'(magnitude_low)) && (mag < 18'(magnitude_high));
    status.cordic_last = (step == LastStep);
    wt = (blend_weight > 17'd65536) ? 17'd65536 : blend_weight;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax <= accel_x; ay <= accel_y; az <= accel_z;
      gx <= rate_x;  gy <= rate_y;
    end
    if (cmd.cordic_start) begin
      step <= '0;
      // quadrant fold when x is negative
      if (az[15]) begin
        px <= -(35'(az) <<< 16); py <= -(35'(ay) <<< 16);
        rx <= -(35'(az) <<< 16); ry <= -(35'(ax) <<< 16);
        pz <= ay[15] ? -Deg180 : Deg180;
        rz <= ax[15] ? -Deg180 : Deg180;
      end else begin
        px <= 35'(az) <<< 16; py <= 35'(ay) <<< 16;
        rx <= 35'(az) <<< 16; ry <= 35'(ax) <<< 16;
        pz <= '0; rz <= '0;
      end
    end else if (cmd.cordic_step) begin
      step <= step + 5'd1;
      if (py > 0) begin
        px <= px + (py >>> step); py <= py - (px >>> step);
        pz <= pz + 34'(ctf_pkg::atan_q24(step));
      end else if (py < 0) begin
        px <= px - (py >>> step); py <= py + (px >>> step);
        pz <= pz - 34'(ctf_pkg::atan_q24(step));
      end
      if (ry > 0) begin
        rx <= rx + (ry >>> step); ry <= ry - (rx >>> step);
        rz <= rz + 34'(ctf_pkg::atan_q24(step));
      end else if (ry < 0) begin
        rx <= rx - (ry >>> step); ry <= ry + (rx >>> step);
        rz <= rz - 34'(ctf_pkg::atan_q24(step));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_angle <= '0;
      roll_angle  <= '0;
      corrected   <= 1'b0;
    end else begin
      if (cmd.load) corrected <= 1'b0;
      if (cmd.gyro) begin
        pitch_angle <= sat34(34'(pitch_angle) + 34'(gyro_delta(gx, gyro_gain)));
        roll_angle  <= sat34(34'(roll_angle) - 34'(gyro_delta(gy, gyro_gain)));
      end
      if (cmd.blend) begin
        pitch_angle <= mix(pitch_angle, round_z(pz), wt);
        roll_angle  <= mix(roll_angle, round_z(rz), wt);
        corrected   <= 1'b1;
      end
    end
  end
endmodule

>>> hdl/complementary_tilt_filter.sv
// top level of the pitch/roll complementary filter
// depends on ctf_pkg, ctf_if, ctf_ctrl, ctf_datapath
//
// usage: one imu word enters on the sample channel (valid/ready), one angle
// word leaves on the angle channel. registers are written through cfg_we,
// cfg_index, cfg_data; the user must do so only while idle, which the block
// itself does not enforce. after acceptance the gyro update runs, then the
// window check; a corrected sample then runs CORDIC_STEPS cordic iterations
// (both angles in parallel on two shift-add units) and a blend step. the
// result is then offered on the angle channel, and the sequencer returns to
// idle before the next word is taken.
// the cordic iteration count and the receiver's ready set the throughput.
// reset zeroes both angles and loads the register defaults.
// a stalled receiver holds the result; no new word is taken until it goes.
module complementary_tilt_filter #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  ctf_sample_if.sink  sample,
  ctf_angle_if.source angle,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  logic [23:0] gyro_gain;
  logic [16:0] blend_weight, magnitude_low, magnitude_high;
  ctf_pkg::ctf_cmd_t cmd;
  ctf_pkg::ctf_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_gain      <= 24'd76;
      blend_weight   <= 17'd64225;
      magnitude_low  <= 17'd8192;
      magnitude_high <= 17'd32768;
    end else if (cfg_we) begin
      case (cfg_index)
        ctf_pkg::REG_GYRO_GAIN: gyro_gain      <= cfg_data;
        ctf_pkg::REG_BLEND:     blend_weight   <= cfg_data[16:0];
        ctf_pkg::REG_MAG_LOW:   magnitude_low  <= cfg_data[16:0];
        ctf_pkg::REG_MAG_HIGH:  magnitude_high <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  ctf_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(sample.valid), .in_ready(sample.ready),
    .out_valid(angle.valid), .out_ready(angle.ready),
    .status, .cmd
  );

  ctf_datapath #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_dp (
    .clk, .rst, .cmd, .status,
    .accel_x(sample.accel_x), .accel_y(sample.accel_y), .accel_z(sample.accel_z),
    .rate_x(sample.rate_x), .rate_y(sample.rate_y),
    .gyro_gain, .blend_weight, .magnitude_low, .magnitude_high,
    .pitch_angle(angle.pitch_out), .roll_angle(angle.roll_out),
    .corrected(angle.corrected)
  );

  // never take a word while a result is on offer
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(sample.ready && angle.valid)) else $error("input taken during output");
  // a result is offered only once: valid drops after the handshake
  a_next: assert property (@(posedge clk) disable iff (rst)
    (angle.valid && angle.ready) |=> !angle.valid) else $error("result repeated");
  // accepted word leaves idle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> !sample.ready) else $error("double accept");
endmodule
